FILE: src/crcg_pkg.sv
`default_nettype none

package crcg_pkg;

   // Default sizes of the block
   localparam int DATA_BITS_DEF    = 32;
   localparam int DIVISOR_BITS_DEF = 33;

   // Fixed field widths
   localparam int DATA_W      = 32;
   localparam int DLEN_W      = 6;
   localparam int POLY_W      = 33;
   localparam int GLEN_W      = 6;
   localparam int CODEWORD_W  = 64;
   localparam int CWLEN_W     = 7;
   localparam int REMAINDER_W = 32;
   localparam int CSR_DATA_W  = 33;
   localparam int CSR_INDEX_W = 1;

   // Register reset values
   localparam logic [POLY_W-1:0] POLY_RESET = 33'd11;
   localparam logic [GLEN_W-1:0] GLEN_RESET = 6'd4;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_DIVISOR_POLY = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIVISOR_LEN  = 1'b1;

   typedef struct packed {
      logic [DATA_W-1:0] data_bits;
      logic [DLEN_W-1:0] data_len;
   } crcg_req_type;

   typedef struct packed {
      logic [CODEWORD_W-1:0]  codeword;
      logic [CWLEN_W-1:0]     codeword_len;
      logic [REMAINDER_W-1:0] remainder;
      logic                   bad_divisor;
   } crcg_rsp_type;

   // Control handed from the sequencer to the row of remainder cells
   typedef struct packed {
      logic clear;
      logic step;
      logic data_bit;
   } crcg_row_ctrl_type;

endpackage

`default_nettype wire

FILE: src/crcg_cell.sv
`default_nettype none

module crcg_cell (
   input  wire                        clock,
   input  crcg_pkg::crcg_row_ctrl_type ctrl,
   input  wire                        prev_bit,
   input  wire                        feedback,
   input  wire                        gen_bit,
   input  wire                        active,
   output logic                       bit_out
);
   import crcg_pkg::*;

   logic bit_ff;
   logic bit_in;

   // One remainder bit: take the neighbor's bit, fold in the generator on feedback
   always_comb begin
      bit_in = bit_ff;
      if (ctrl.clear) begin
         bit_in = 1'b0;
      end else if (ctrl.step) begin
         bit_in = active & (prev_bit ^ (feedback & gen_bit));
      end
   end

   always_ff @(posedge clock) begin
      bit_ff <= bit_in;
   end

   assign bit_out = bit_ff;

endmodule

`default_nettype wire

FILE: src/crcg_cell_row.sv
`default_nettype none

module crcg_cell_row #(
   parameter int REM_BITS = crcg_pkg::DIVISOR_BITS_DEF - 1
) (
   input  wire                          clock,
   input  crcg_pkg::crcg_row_ctrl_type  ctrl,
   input  wire [crcg_pkg::POLY_W-1:0]   poly,
   input  wire [crcg_pkg::GLEN_W-1:0]   glen,
   output logic [REM_BITS-1:0]          rem
);
   import crcg_pkg::*;

   logic [REM_BITS-1:0] prev;
   logic [REM_BITS-1:0] top_sel;
   logic [REM_BITS-1:0] active;
   logic                feedback;

   // Top remainder bit sits at glen-2; cells at or above glen-1 stay clear
   always_comb begin
      for (int k = 0; k < REM_BITS; k++) begin
         top_sel[k] = (glen == GLEN_W'(k + 2));
         active[k]  = (glen > GLEN_W'(k + 1));
      end
      feedback = ctrl.data_bit ^ (|(rem & top_sel));
   end

   for (genvar k = 0; k < REM_BITS; k++) begin : g_cell
      if (k == 0) begin : g_first
         assign prev[k] = 1'b0;
      end else begin : g_rest
         assign prev[k] = rem[k-1];
      end

      crcg_cell u_cell (
         .clock    (clock),
         .ctrl     (ctrl),
         .prev_bit (prev[k]),
         .feedback (feedback),
         .gen_bit  (poly[k]),
         .active   (active[k]),
         .bit_out  (rem[k])
      );
   end

endmodule

`default_nettype wire

FILE: src/crc_codeword_generator_core.sv
`default_nettype none
// The sequencer accepts an item, steps the row once per data bit (data_len clamped to
//   DATA_BITS), then loads the result into the output register once that register is free;
//   an item with a bad divisor skips the stepping. The row of remainder cells takes one
//   dataword bit per cycle and handles one item at a time; req_stall holds off a new item until the sequencer is idle.
// A finished item waits in the output register while the next item is accepted.
// Reset is synchronous, active high: clears the sequencer and output valid, loads
//   divisor_poly with 11 and divisor_len with 4.

module crc_codeword_generator_core #(
   parameter int DATA_BITS    = crcg_pkg::DATA_BITS_DEF,
   parameter int DIVISOR_BITS = crcg_pkg::DIVISOR_BITS_DEF
) (
   input  wire                              clock,
   input  wire                              reset,
   // item input
   input  wire                              req_valid,
   output logic                             req_stall,
   input  crcg_pkg::crcg_req_type           req_data,
   // result output
   output logic                             rsp_valid,
   input  wire                              rsp_stall,
   output crcg_pkg::crcg_rsp_type           rsp_data,
   // configuration writes
   input  wire                              csr_we,
   input  wire [crcg_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire [crcg_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import crcg_pkg::*;

   localparam int REM_BITS = DIVISOR_BITS - 1;
   localparam int CNT_W    = $clog2(DATA_BITS + 1);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } state_type;

   // Configuration registers
   logic [POLY_W-1:0] poly_ff, poly_in;
   logic [GLEN_W-1:0] glen_ff, glen_in;

   // Sequencer and per-item registers
   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DATA_W-1:0] data_ff, data_in;     // masked dataword, right aligned
   logic [DATA_W-1:0] shift_ff, shift_in;   // dataword left aligned, MSB feeds the row
   logic [DLEN_W-1:0] dlen_ff, dlen_in;
   logic              bad_ff, bad_in;

   // Output register
   logic         rsp_valid_ff, rsp_valid_in;
   crcg_rsp_type rsp_data_ff, rsp_data_in;

   logic                accept;
   logic                out_free;
   logic                finish;
   logic [DLEN_W-1:0]   dlen_sat;
   logic [DATA_W-1:0]   data_masked;
   logic [POLY_W-1:0]   poly_top;
   logic                bad_now;
   logic [REM_BITS-1:0] rem;
   logic [CODEWORD_W-1:0] cw_shifted;
   crcg_row_ctrl_type   row_ctrl;

   // Configuration: take writes as they come
   always_comb begin
      poly_in = poly_ff;
      glen_in = glen_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_DIVISOR_POLY: poly_in = csr_wdata;
            CSR_DIVISOR_LEN:  glen_in = csr_wdata[GLEN_W-1:0];
            default: ;
         endcase
      end
   end

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign finish   = (state_ff == ST_RUN) && (cnt_ff == '0) && out_free;

   // Clamp the length, drop stray data bits above it
   always_comb begin
      dlen_sat = (req_data.data_len > DLEN_W'(DATA_BITS)) ? DLEN_W'(DATA_BITS)
                                                          : req_data.data_len;
      for (int i = 0; i < DATA_W; i++) begin
         data_masked[i] = req_data.data_bits[i] & (DLEN_W'(i) < dlen_sat);
      end
   end

   // The polynomial needs its top coefficient set and a length in range
   always_comb begin
      poly_top = poly_ff >> (glen_ff - GLEN_W'(1));
      bad_now  = (glen_ff < GLEN_W'(2)) || (glen_ff > GLEN_W'(DIVISOR_BITS)) || !poly_top[0];
   end

   // Sequencer: load an item, step one bit per cycle, hand off to the output register
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      data_in  = data_ff;
      shift_in = shift_ff;
      dlen_in  = dlen_ff;
      bad_in   = bad_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_RUN;
               data_in  = data_masked;
               shift_in = data_masked << (DLEN_W'(DATA_W) - dlen_sat);
               dlen_in  = dlen_sat;
               bad_in   = bad_now;
               // a bad divisor skips the division entirely
               cnt_in   = bad_now ? '0 : CNT_W'(dlen_sat);
            end
         end
         ST_RUN: begin
            if (cnt_ff != '0) begin
               cnt_in   = cnt_ff - CNT_W'(1);
               shift_in = shift_ff << 1;
            end else if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign row_ctrl.clear    = accept;
   assign row_ctrl.step     = (state_ff == ST_RUN) && (cnt_ff != '0);
   assign row_ctrl.data_bit = shift_ff[DATA_W-1];

   crcg_cell_row #(
      .REM_BITS (REM_BITS)
   ) u_row (
      .clock (clock),
      .ctrl  (row_ctrl),
      .poly  (poly_ff),
      .glen  (glen_ff),
      .rem   (rem)
   );

   // Codeword: dataword moved up by the remainder width, remainder in the low bits
   assign cw_shifted = CODEWORD_W'(data_ff) << (glen_ff - GLEN_W'(1));

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
         if (bad_ff) begin
            rsp_data_in             = '0;
            rsp_data_in.bad_divisor = 1'b1;
         end else begin
            rsp_data_in.codeword     = cw_shifted | CODEWORD_W'(rem);
            rsp_data_in.codeword_len = CWLEN_W'(dlen_ff) + CWLEN_W'(glen_ff) - CWLEN_W'(1);
            rsp_data_in.remainder    = REMAINDER_W'(rem);
            rsp_data_in.bad_divisor  = 1'b0;
         end
      end else if (!rsp_stall) begin
         // drop the item once taken
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         poly_ff      <= POLY_RESET;
         glen_ff      <= GLEN_RESET;
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         poly_ff      <= poly_in;
         glen_ff      <= glen_in;
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff     <= data_in;
      shift_ff    <= shift_in;
      dlen_ff     <= dlen_in;
      bad_ff      <= bad_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // An accepted item always moves the sequencer to ST_RUN
   a_accept_runs: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_RUN))
      else $error("accepted item did not start");

   // The bit counter only counts down by one while stepping
   a_cnt_down: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RUN && cnt_ff != '0) |=> (cnt_ff == $past(cnt_ff) - CNT_W'(1)))
      else $error("bit counter skipped");

   // A new result appears only after the last bit was processed
   a_result_after_run: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_RUN && cnt_ff == '0))
      else $error("result loaded before division ended");

   // A bad divisor clears every other result field
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.bad_divisor) |->
         (rsp_data_ff.codeword == '0 && rsp_data_ff.remainder == '0 &&
          rsp_data_ff.codeword_len == '0))
      else $error("bad divisor result carries data");

endmodule

`default_nettype wire
